/* src/key_matrix_scan_event_queue_macros.svh */
// Assertion macros shared by the key matrix scan event queue RTL.
`ifndef KEY_MATRIX_SCAN_EVENT_QUEUE_MACROS_SVH
`define KEY_MATRIX_SCAN_EVENT_QUEUE_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define KMSQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define KMSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kmsq_pkg.sv */
// Shared types and constants for the key matrix scan event queue.
package kmsq_pkg;

    localparam int ROW_W = 3;
    localparam int COL_W = 8;
    localparam int KEY_W = 7;

    localparam logic KIND_SCAN = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    localparam int SHIFT_ROW_A     = 3;
    localparam int SHIFT_BIT_A     = 0;
    localparam int SHIFT_ROW_B     = 5;
    localparam int SHIFT_BIT_B     = 6;
    localparam int CONTROL_KEY_ROW = 2;
    localparam int CONTROL_KEY_BIT = 0;

    typedef struct packed {
        logic             ctrl;
        logic             shift;
        logic [KEY_W-1:0] key;
    } t_event;

    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_push;

endpackage

/* src/kmsq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kmsq_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/kmsq_scan.sv */
// Per-row column history, key press detection and modifier sampling.
module kmsq_scan #(
    parameter int ROW_COUNT = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_scan,
    input  logic [kmsq_pkg::ROW_W-1:0] i_row,
    input  logic [kmsq_pkg::COL_W-1:0] i_columns,
    output kmsq_pkg::t_push            o_push
);

    logic [kmsq_pkg::COL_W-1:0] r_prev [ROW_COUNT];
    logic [kmsq_pkg::COL_W-1:0] n_prev [ROW_COUNT];
    logic [kmsq_pkg::COL_W-1:0] w_sel;
    logic [kmsq_pkg::COL_W-1:0] w_diff;
    logic [kmsq_pkg::ROW_W-1:0] w_col;
    logic                       w_hit;
    logic                       w_changed;
    logic                       w_press;
    logic                       w_shift;
    logic                       w_ctrl;

    always_comb begin
        w_hit = i_scan && ({1'b0, i_row} < (kmsq_pkg::ROW_W + 1)'(ROW_COUNT));
        w_sel = '0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (i_row == kmsq_pkg::ROW_W'(r)) begin
                w_sel = r_prev[r];
            end
        end
        w_diff    = i_columns ^ w_sel;
        w_changed = w_hit && (w_diff != '0);
        w_press   = w_changed && ((w_diff & i_columns) == '0);

        // The highest-numbered low column wins.
        w_col = '0;
        for (int i = 0; i < kmsq_pkg::COL_W; i++) begin
            if (!i_columns[i]) begin
                w_col = kmsq_pkg::ROW_W'(i);
            end
        end

        for (int r = 0; r < ROW_COUNT; r++) begin
            n_prev[r] = (w_changed && (i_row == kmsq_pkg::ROW_W'(r))) ? i_columns : r_prev[r];
        end

        // Modifiers are sampled after this row's update.
        w_shift = 1'b0;
        w_ctrl  = 1'b0;
        for (int r = 0; r < ROW_COUNT; r++) begin
            if (r == kmsq_pkg::SHIFT_ROW_A && !n_prev[r][kmsq_pkg::SHIFT_BIT_A]) begin
                w_shift = 1'b1;
            end
            if (r == kmsq_pkg::SHIFT_ROW_B && !n_prev[r][kmsq_pkg::SHIFT_BIT_B]) begin
                w_shift = 1'b1;
            end
            if (r == kmsq_pkg::CONTROL_KEY_ROW && !n_prev[r][kmsq_pkg::CONTROL_KEY_BIT]) begin
                w_ctrl = 1'b1;
            end
        end

        o_push.valid     = w_press;
        o_push.evt.ctrl  = w_ctrl;
        o_push.evt.shift = w_shift;
        o_push.evt.key   = kmsq_pkg::KEY_W'({i_row, w_col}) + kmsq_pkg::KEY_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '{default: '0};
        end else begin
            r_prev <= n_prev;
        end
    end

endmodule

/* src/kmsq_ring.sv */
// Event ring with read and write pointers around a RAM.
`include "key_matrix_scan_event_queue_macros.svh"

module kmsq_ring #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  kmsq_pkg::t_push  i_push,
    input  logic             i_pop,
    output logic             o_empty,
    output kmsq_pkg::t_event o_rdata
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic             w_full;
    logic             w_we;
    logic             w_re;

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        o_empty  = (r_rd_ptr == r_wr_ptr);
        w_full   = (n_wr_ptr == r_rd_ptr);
        w_we     = i_push.valid && !w_full;
        w_re     = i_pop && !o_empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (w_we) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (w_re) begin
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

    kmsq_ram #(
        .WIDTH($bits(kmsq_pkg::t_event)),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(i_push.evt),
        .i_re   (w_re),
        .i_raddr(r_rd_ptr),
        .o_rdata(o_rdata)
    );

    `KMSQ_ASSERT_NEXT(a_full_drops, i_clk, i_rst_n, i_push.valid && w_full, $stable(r_wr_ptr), "push into a full ring moved the write pointer")
    `KMSQ_ASSERT_NEXT(a_pop_moves, i_clk, i_rst_n, i_pop && !o_empty, r_rd_ptr != $past(r_rd_ptr), "pop of a queued item did not advance")
    `KMSQ_ASSERT_SAME(a_no_clash, i_clk, i_rst_n, i_pop, !i_push.valid, "push and pop in the same cycle")

endmodule

/* src/key_matrix_scan_event_queue.sv */
// Top level of the key matrix scan event queue.
//
// An input item is either a row scan (kind low) carrying a row number and its
// active-low column word, or a pop request (kind high). Row scans return
// nothing; they update the stored column word of the row and may queue a key
// press event together with the shift and ctrl state. A pop returns one
// result item: the oldest queued event, or zero fields with was_empty set.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. Items enter an input register and are processed from there;
// a pop result is registered in the output register. One item per cycle is
// sustained as long as the receiver keeps taking results. When the receiver
// stalls, a pending pop result holds and a pop waiting behind it holds the
// input register, which raises o_in_stall; row scans still drain while no pop
// is waiting. Reset clears the stored column words to all pressed, empties
// the event ring and drops any item in flight. The ring holds one event less
// than its depth; further events are dropped.
`include "key_matrix_scan_event_queue_macros.svh"

module key_matrix_scan_event_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ROW_COUNT   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic [kmsq_pkg::ROW_W-1:0] i_row,
    input  logic [kmsq_pkg::COL_W-1:0] i_columns,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [kmsq_pkg::KEY_W-1:0] o_key_number,
    output logic                       o_shift_held,
    output logic                       o_ctrl_held,
    output logic                       o_was_empty
);

    logic                       r_in_valid;
    logic                       r_in_kind;
    logic [kmsq_pkg::ROW_W-1:0] r_row;
    logic [kmsq_pkg::COL_W-1:0] r_columns;
    logic                       r_out_valid;
    logic                       r_out_empty;
    logic                       w_out_free;
    logic                       w_adv;
    logic                       w_pop;
    logic                       w_empty;
    kmsq_pkg::t_push            w_push;
    kmsq_pkg::t_event           w_rdata;

    always_comb begin
        w_out_free = !r_out_valid || !i_out_stall;
        w_adv      = r_in_valid && ((r_in_kind == kmsq_pkg::KIND_SCAN) || w_out_free);
        w_pop      = w_adv && (r_in_kind == kmsq_pkg::KIND_POP);
        o_in_stall = r_in_valid && !w_adv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in_kind <= i_kind;
            r_row     <= i_row;
            r_columns <= i_columns;
        end
        if (w_pop) begin
            r_out_empty <= w_empty;
        end
    end

    kmsq_scan #(
        .ROW_COUNT(ROW_COUNT)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_scan   (w_adv && (r_in_kind == kmsq_pkg::KIND_SCAN)),
        .i_row    (r_row),
        .i_columns(r_columns),
        .o_push   (w_push)
    );

    kmsq_ring #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_rdata(w_rdata)
    );

    assign o_out_valid  = r_out_valid;
    assign o_was_empty  = r_out_empty;
    assign o_key_number = r_out_empty ? '0 : w_rdata.key;
    assign o_shift_held = !r_out_empty && w_rdata.shift;
    assign o_ctrl_held  = !r_out_empty && w_rdata.ctrl;

    `KMSQ_ASSERT_NEXT(a_held_item, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid, "held item was lost")
    `KMSQ_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, w_pop, r_out_valid, "pop did not produce a result")
    `KMSQ_ASSERT_SAME(a_pop_room, i_clk, i_rst_n, w_pop, w_out_free, "pop advanced into a full output register")

endmodule
